/* sv/jgdc_pkg.sv */
// ----------------------------------------------------------------------------
// jgdc_pkg: shared types, constants and microprogram
// Widths, conversion constants, micro-op codes and the control store of the
// Julian Day number / calendar date converter.
// ----------------------------------------------------------------------------
package jgdc_pkg;

    // stream and register port geometry
    localparam int TDATA_W     = 56;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TUSER_W = 1;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_EPOCH = 1'b0;

    // field widths
    localparam int EPOCH_W = 22;
    localparam int CAL_W   = 3;
    localparam int YEAR_W  = 18;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int JD_W    = 27;

    // datapath widths
    localparam int Y_W     = 19;   // working year, holds the day-to-date span
    localparam int ACC_W   = 29;   // day number accumulator
    localparam int U_W     = 20;   // biased year, always positive
    localparam int Q_W     = 14;   // biased year / 100
    localparam int MAG_W   = 27;   // |jd - epoch|
    localparam int RECIP_W = 24;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int TERM_W  = 20;
    localparam int OFF_W   = 9;    // day within year

    localparam logic [EPOCH_W-1:0] EPOCH_RESET = 22'd1721060;

    localparam logic [CAL_W-1:0] CAL_GREGORIAN = 3'd0;
    localparam logic [CAL_W-1:0] CAL_JULIAN    = 3'd1;

    localparam logic signed [Y_W-1:0] YEAR_MAX = 19'sd99999;
    localparam logic signed [Y_W-1:0] YEAR_MIN = -19'sd99999;

    // year + BIAS is positive and a multiple of 400 away from year, so floor
    // divisions and remainders of the year follow from plain unsigned ones
    localparam logic signed [U_W:0]      YEAR_BIAS = 21'sd409600;
    // BIAS/4 - BIAS/100 + BIAS/400, and BIAS/4 plus the two-day shift
    localparam logic signed [TERM_W-1:0] TERM_BIAS_GREG = 20'sd99328;
    localparam logic signed [TERM_W-1:0] TERM_BIAS_JUL  = 20'sd102402;

    // reciprocals: ceil(2^27/100) is exact over the biased year range;
    // 2^32/365.2425 and 2^32/365.25 give a year estimate within a few years
    localparam logic [RECIP_W-1:0] RECIP_100  = 24'd1342178;
    localparam logic [RECIP_W-1:0] RECIP_GREG = 24'd11759221;
    localparam logic [RECIP_W-1:0] RECIP_JUL  = 24'd11758980;
    localparam int Q_SHIFT   = 27;
    localparam int EST_SHIFT = 32;

    localparam logic [OFF_W-1:0] COMMON_YEAR_DAYS = 9'd365;

    // micro-operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_EST_DIFF = 4'd1;
    localparam logic [3:0] OP_EST_MUL  = 4'd2;
    localparam logic [3:0] OP_EST_Y    = 4'd3;
    localparam logic [3:0] OP_MUL365   = 4'd4;
    localparam logic [3:0] OP_MUL100   = 4'd5;
    localparam logic [3:0] OP_TERM     = 4'd6;
    localparam logic [3:0] OP_NEWYEAR  = 4'd7;
    localparam logic [3:0] OP_ADJUST   = 4'd8;
    localparam logic [3:0] OP_MONTH    = 4'd9;
    localparam logic [3:0] OP_DAY      = 4'd10;
    localparam logic [3:0] OP_DATE_SUM = 4'd11;
    localparam logic [3:0] OP_FINISH   = 4'd12;
    localparam logic [3:0] OP_FAIL     = 4'd13;

    // jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_BAD      = 3'd2;
    localparam logic [2:0] COND_DATE     = 3'd3;
    localparam logic [2:0] COND_OUTSIDE  = 3'd4;
    localparam logic [2:0] COND_YEAR_BAD = 3'd5;

    localparam int STEP_W   = 4;
    localparam int PROG_LEN = 14;

    localparam logic [STEP_W-1:0] STEP_NONE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_NEW_YEAR = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DATE_SUM = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_FAIL     = 4'd13;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ctrl_word_t;

    // control to the datapath
    typedef struct packed {
        logic       en;
        logic [3:0] op;
    } ctrl_t;

    // status from the datapath
    typedef struct packed {
        logic bad;
        logic date_kind;
        logic outside;
        logic year_bad;
    } flags_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [JD_W-1:0]    day_number;
    } res_t;

    localparam ctrl_word_t PROGRAM [PROG_LEN] = '{
        '{OP_NOP,      COND_BAD,      STEP_FAIL},      // 0
        '{OP_EST_DIFF, COND_DATE,     STEP_NEW_YEAR},  // 1
        '{OP_EST_MUL,  COND_NEVER,    STEP_NONE},      // 2
        '{OP_EST_Y,    COND_NEVER,    STEP_NONE},      // 3
        '{OP_MUL365,   COND_NEVER,    STEP_NONE},      // 4
        '{OP_MUL100,   COND_NEVER,    STEP_NONE},      // 5
        '{OP_TERM,     COND_NEVER,    STEP_NONE},      // 6
        '{OP_NEWYEAR,  COND_DATE,     STEP_DATE_SUM},  // 7
        '{OP_ADJUST,   COND_OUTSIDE,  STEP_NEW_YEAR},  // 8
        '{OP_MONTH,    COND_YEAR_BAD, STEP_FAIL},      // 9
        '{OP_DAY,      COND_ALWAYS,   STEP_FINISH},    // 10
        '{OP_DATE_SUM, COND_NEVER,    STEP_NONE},      // 11
        '{OP_FINISH,   COND_NEVER,    STEP_NONE},      // 12
        '{OP_FAIL,     COND_NEVER,    STEP_NONE}       // 13
    };

    // days in the months before month m; months above twelve give the year
    function automatic logic [OFF_W-1:0] cum_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [OFF_W-1:0] base;
        unique case (m)
            4'd0, 4'd1: base = 9'd0;
            4'd2:       base = 9'd31;
            4'd3:       base = 9'd59;
            4'd4:       base = 9'd90;
            4'd5:       base = 9'd120;
            4'd6:       base = 9'd151;
            4'd7:       base = 9'd181;
            4'd8:       base = 9'd212;
            4'd9:       base = 9'd243;
            4'd10:      base = 9'd273;
            4'd11:      base = 9'd304;
            4'd12:      base = 9'd334;
            default:    base = 9'd365;
        endcase
        return base + {8'b0, (leap && (m >= 4'd3))};
    endfunction

endpackage

/* sv/jgdc_seq.sv */
// ----------------------------------------------------------------------------
// jgdc_seq: microprogram sequencer
// Step counter over the control store with conditional jumps; holds on the
// result step until the output register is free.
// ----------------------------------------------------------------------------
module jgdc_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  jgdc_pkg::flags_t flags,
    input  logic             out_free,
    output jgdc_pkg::ctrl_t  ctrl,
    output logic             busy
);

    logic [jgdc_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    jgdc_pkg::ctrl_word_t        word;
    logic                        last, hold, take;

    assign word = jgdc_pkg::PROGRAM[step_reg];
    assign last = (word.op == jgdc_pkg::OP_FINISH) || (word.op == jgdc_pkg::OP_FAIL);
    assign hold = last && !out_free;

    always_comb begin
        unique case (word.cond)
            jgdc_pkg::COND_NEVER:    take = 1'b0;
            jgdc_pkg::COND_ALWAYS:   take = 1'b1;
            jgdc_pkg::COND_BAD:      take = flags.bad;
            jgdc_pkg::COND_DATE:     take = flags.date_kind;
            jgdc_pkg::COND_OUTSIDE:  take = flags.outside;
            jgdc_pkg::COND_YEAR_BAD: take = flags.year_bad;
            default:                 take = 1'b0;
        endcase
    end

    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end else if (!hold) begin
            if (last) begin
                busy_next = 1'b0;
            end else if (take) begin
                step_next = word.target;
            end else begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctrl.en = busy_reg && !hold;
    assign ctrl.op = word.op;
    assign busy    = busy_reg;

endmodule

/* sv/jgdc_dp.sv */
// ----------------------------------------------------------------------------
// jgdc_dp: conversion datapath
// Year estimate, New Year's Day number, year correction, month search and the
// date-to-day sum, one micro-operation per enabled cycle.
// ----------------------------------------------------------------------------
module jgdc_dp (
    input  logic                               aclk,
    input  logic                               load,
    input  logic                               kind,
    input  logic [jgdc_pkg::CAL_W-1:0]         calendar_kind,
    input  logic signed [jgdc_pkg::YEAR_W-1:0] year_number,
    input  logic [jgdc_pkg::MONTH_W-1:0]       month_number,
    input  logic [jgdc_pkg::DAY_W-1:0]         day_of_month,
    input  logic signed [jgdc_pkg::JD_W-1:0]   day_number_in,
    input  logic [jgdc_pkg::EPOCH_W-1:0]       epoch,
    input  jgdc_pkg::ctrl_t                    ctrl,
    output jgdc_pkg::flags_t                   flags,
    output jgdc_pkg::res_t                     res
);

    logic                                kind_reg, jul_reg, cal_bad_reg;
    logic signed [jgdc_pkg::Y_W-1:0]     y_reg, y_next;
    logic [jgdc_pkg::MONTH_W-1:0]        mon_reg;
    logic [jgdc_pkg::DAY_W-1:0]          dom_reg;
    logic signed [jgdc_pkg::JD_W-1:0]    jd_reg;
    logic                                neg_reg;
    logic [jgdc_pkg::MAG_W-1:0]          mag_reg;
    logic [jgdc_pkg::PROD_W-1:0]         prod_reg;
    logic signed [jgdc_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic                                leap_reg;
    logic signed [jgdc_pkg::TERM_W-1:0]  term_reg;
    logic [jgdc_pkg::OFF_W-1:0]          off_reg;
    logic [jgdc_pkg::MONTH_W-1:0]        month_reg, month_next;
    logic [jgdc_pkg::DAY_W-1:0]          day_reg;

    logic signed [jgdc_pkg::ACC_W-1:0]   jd_ext, epoch_ext, diff_fwd, diff_rev, dd;
    logic signed [jgdc_pkg::U_W:0]       u_sum;
    logic [jgdc_pkg::U_W-1:0]            u, q100;
    logic [jgdc_pkg::Q_W-1:0]            q;
    logic                                rem0, leap_now;
    logic signed [jgdc_pkg::TERM_W-1:0]  u_quarter, term_now;
    logic [jgdc_pkg::MAG_W-1:0]          mul_a;
    logic [jgdc_pkg::RECIP_W-1:0]        mul_b;
    logic [jgdc_pkg::PROD_W-1:0]         mul_p;
    logic [jgdc_pkg::Y_W-1:0]            y_est;
    logic [jgdc_pkg::OFF_W-1:0]          year_len, day_sum;
    logic                                year_bad;

    assign jd_ext    = {{(jgdc_pkg::ACC_W - jgdc_pkg::JD_W){jd_reg[jgdc_pkg::JD_W-1]}}, jd_reg};
    assign epoch_ext = {{(jgdc_pkg::ACC_W - jgdc_pkg::EPOCH_W){1'b0}}, epoch};
    assign diff_fwd  = jd_ext - epoch_ext;
    assign diff_rev  = epoch_ext - jd_ext;

    // biased year and its quotient by 100
    assign u_sum = {{2{y_reg[jgdc_pkg::Y_W-1]}}, y_reg} + jgdc_pkg::YEAR_BIAS;
    assign u     = u_sum[jgdc_pkg::U_W-1:0];
    assign q     = prod_reg[jgdc_pkg::Q_SHIFT +: jgdc_pkg::Q_W];
    assign q100  = {{(jgdc_pkg::U_W - jgdc_pkg::Q_W){1'b0}}, q} * 20'd100;
    assign rem0  = (u == q100);

    assign leap_now  = (y_reg[1:0] == 2'b00) && (jul_reg || !rem0 || (q[1:0] == 2'b00));
    assign u_quarter = $signed({2'b00, u[jgdc_pkg::U_W-1:2]});
    assign term_now  = jul_reg
        ? (u_quarter - jgdc_pkg::TERM_BIAS_JUL)
        : (u_quarter - $signed({6'b0, q}) + $signed({8'b0, q[jgdc_pkg::Q_W-1:2]})
           - jgdc_pkg::TERM_BIAS_GREG);

    // one shared unsigned multiplier: year estimate and the divide by 100
    assign mul_a = (ctrl.op == jgdc_pkg::OP_EST_MUL)
        ? mag_reg : {{(jgdc_pkg::MAG_W - jgdc_pkg::U_W){1'b0}}, u};
    assign mul_b = (ctrl.op == jgdc_pkg::OP_EST_MUL)
        ? (jul_reg ? jgdc_pkg::RECIP_JUL : jgdc_pkg::RECIP_GREG) : jgdc_pkg::RECIP_100;
    assign mul_p = {{jgdc_pkg::RECIP_W{1'b0}}, mul_a} * {{jgdc_pkg::MAG_W{1'b0}}, mul_b};

    assign y_est = prod_reg[jgdc_pkg::EST_SHIFT +: jgdc_pkg::Y_W];

    // offset of the day from New Year's Day
    assign dd       = jd_ext - acc_reg;
    assign year_len = jgdc_pkg::COMMON_YEAR_DAYS + {8'b0, leap_reg};
    assign day_sum  = off_reg - jgdc_pkg::cum_before(month_reg, leap_reg) + 9'd1;

    assign year_bad = (y_reg > jgdc_pkg::YEAR_MAX) || (y_reg < jgdc_pkg::YEAR_MIN);

    always_comb begin
        month_next = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (off_reg >= jgdc_pkg::cum_before(4'(k), leap_reg)) begin
                month_next = 4'(k);
            end
        end
    end

    always_comb begin
        y_next   = y_reg;
        acc_next = acc_reg;
        case (ctrl.op)
            jgdc_pkg::OP_EST_Y: begin
                y_next = neg_reg ? -$signed(y_est) : $signed(y_est);
            end
            jgdc_pkg::OP_MUL365: begin
                acc_next = $signed({{(jgdc_pkg::ACC_W - jgdc_pkg::Y_W){y_reg[jgdc_pkg::Y_W-1]}},
                                    y_reg}) * 29'sd365;
            end
            jgdc_pkg::OP_NEWYEAR: begin
                acc_next = acc_reg
                    + {{(jgdc_pkg::ACC_W - jgdc_pkg::TERM_W){term_reg[jgdc_pkg::TERM_W-1]}},
                       term_reg}
                    - {{(jgdc_pkg::ACC_W - 1){1'b0}}, leap_reg}
                    + epoch_ext + 29'sd1;
            end
            jgdc_pkg::OP_ADJUST: begin
                // step one year toward the one that holds the day
                if (dd < 0) begin
                    y_next = y_reg - 19'sd1;
                end else if (dd >= $signed({20'b0, year_len})) begin
                    y_next = y_reg + 19'sd1;
                end
            end
            jgdc_pkg::OP_DATE_SUM: begin
                acc_next = acc_reg
                    + $signed({20'b0, jgdc_pkg::cum_before(mon_reg, leap_reg)})
                    + $signed({24'b0, dom_reg}) - 29'sd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg    <= kind;
            jul_reg     <= (calendar_kind == jgdc_pkg::CAL_JULIAN);
            cal_bad_reg <= (calendar_kind != jgdc_pkg::CAL_JULIAN)
                        && (calendar_kind != jgdc_pkg::CAL_GREGORIAN);
            y_reg       <= {year_number[jgdc_pkg::YEAR_W-1], year_number};
            mon_reg     <= month_number;
            dom_reg     <= day_of_month;
            jd_reg      <= day_number_in;
        end else if (ctrl.en) begin
            y_reg   <= y_next;
            acc_reg <= acc_next;
            case (ctrl.op)
                jgdc_pkg::OP_EST_DIFF: begin
                    neg_reg <= diff_fwd[jgdc_pkg::ACC_W-1];
                    mag_reg <= diff_fwd[jgdc_pkg::ACC_W-1]
                        ? diff_rev[jgdc_pkg::MAG_W-1:0] : diff_fwd[jgdc_pkg::MAG_W-1:0];
                end
                jgdc_pkg::OP_EST_MUL, jgdc_pkg::OP_MUL100: begin
                    prod_reg <= mul_p;
                end
                jgdc_pkg::OP_TERM: begin
                    leap_reg <= leap_now;
                    term_reg <= term_now;
                end
                jgdc_pkg::OP_ADJUST: begin
                    off_reg <= dd[jgdc_pkg::OFF_W-1:0];
                end
                jgdc_pkg::OP_MONTH: begin
                    month_reg <= month_next;
                end
                jgdc_pkg::OP_DAY: begin
                    day_reg <= day_sum[jgdc_pkg::DAY_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign flags.bad       = cal_bad_reg || (!kind_reg && year_bad);
    assign flags.date_kind = !kind_reg;
    assign flags.outside   = (dd < 0) || (dd >= $signed({20'b0, year_len}));
    assign flags.year_bad  = year_bad;

    assign res.day_number = kind_reg ? '0 : acc_reg[jgdc_pkg::JD_W-1:0];
    assign res.year       = kind_reg ? y_reg[jgdc_pkg::YEAR_W-1:0] : '0;
    assign res.month      = kind_reg ? month_reg : '0;
    assign res.day        = kind_reg ? day_reg : '0;

endmodule

/* sv/julian_gregorian_date_converter.sv */
// ----------------------------------------------------------------------------
// julian_gregorian_date_converter: Julian Day number / calendar date converter
// Converts dates to day numbers and back for the Gregorian and Julian
// calendars, proleptic, with signed astronomical years.
//
//   group   direction  contents
//   s_*     in         tuser: kind, calendar_kind; tdata: year, month, day, jd
//   m_*     out        tuser: error; tdata: jd, year, month, day
//   p*      in/out     APB register port, epoch_offset at byte address 0
//
// Day to date repeats a year step for each year tried by the correction loop.
// An invalid calendar or date-to-day year errors at the first step; a year
// found out of range in day to date errors at the month step instead of a
// full result. One control word per cycle.
// Synchronous active-low reset clears sequencer, output valid; presets epoch.
// A waiting result does not block input; the result step holds while full.
// ----------------------------------------------------------------------------
module julian_gregorian_date_converter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // year_number[17:0], month_number[21:18], day_of_month[26:22],
    // day_number_in[53:27], zero pad[55:54]
    input  logic [jgdc_pkg::TDATA_W-1:0]         s_tdata,
    // kind[0], calendar_kind[3:1]
    input  logic [jgdc_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // day_number_out[26:0], year_out[44:27], month_out[48:45], day_out[53:49],
    // zero pad[55:54]
    output logic [jgdc_pkg::TDATA_W-1:0]         m_tdata,
    // error[0]
    output logic [jgdc_pkg::OUT_TUSER_W-1:0]     m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [jgdc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [jgdc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [jgdc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [jgdc_pkg::EPOCH_W-1:0]     epoch_reg;
    logic                             load, busy, out_free, emit;
    jgdc_pkg::ctrl_t                  ctrl;
    jgdc_pkg::flags_t                 flags;
    jgdc_pkg::res_t                   res;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [jgdc_pkg::TDATA_W-1:0]     m_tdata_reg;
    logic [jgdc_pkg::OUT_TUSER_W-1:0] m_tuser_reg;
    logic [jgdc_pkg::REG_IDX_W-1:0]   reg_idx;

    // configuration register
    assign pready  = 1'b1;
    assign reg_idx = paddr[jgdc_pkg::APB_ADDR_W-1:2];
    assign prdata  = (reg_idx == jgdc_pkg::REG_EPOCH)
        ? {{(jgdc_pkg::APB_DATA_W - jgdc_pkg::EPOCH_W){1'b0}}, epoch_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg <= jgdc_pkg::EPOCH_RESET;
        end else if (psel && penable && pwrite && pready
                     && (reg_idx == jgdc_pkg::REG_EPOCH)) begin
            epoch_reg <= pwdata[jgdc_pkg::EPOCH_W-1:0];
        end
    end

    assign s_tready = !busy;
    assign load     = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    jgdc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (load),
        .flags    (flags),
        .out_free (out_free),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    jgdc_dp u_dp (
        .aclk          (aclk),
        .load          (load),
        .kind          (s_tuser[0]),
        .calendar_kind (s_tuser[3:1]),
        .year_number   (s_tdata[17:0]),
        .month_number  (s_tdata[21:18]),
        .day_of_month  (s_tdata[26:22]),
        .day_number_in (s_tdata[53:27]),
        .epoch         (epoch_reg),
        .ctrl          (ctrl),
        .flags         (flags),
        .res           (res)
    );

    assign emit = ctrl.en
        && ((ctrl.op == jgdc_pkg::OP_FINISH) || (ctrl.op == jgdc_pkg::OP_FAIL));

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // an error result carries zeros in every data field
    always_ff @(posedge aclk) begin
        if (emit) begin
            if (ctrl.op == jgdc_pkg::OP_FAIL) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 1'b1;
            end else begin
                m_tdata_reg <= {2'b00, res};
                m_tuser_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // no second transaction while one is being converted
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a conversion is in progress");

    // a result only leaves the sequencer when the output register can take it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result written over one not yet taken");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error result with nonzero fields");

    a_date_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0] && (m_tdata[48:45] != 4'd0))
        |-> ((m_tdata[48:45] <= 4'd12) && (m_tdata[53:49] != 5'd0)
             && (m_tdata[26:0] == 27'd0)))
        else $error("calendar date result out of range");

endmodule
